// ===== design/xtks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package xtks_pkg;

    localparam int VALUE_BITS_DEF = 18;
    localparam int MAX_ITEMS_DEF  = 65536;
    localparam int OP_BITS        = 2;
    localparam int OPERAND_BITS   = 18;
    localparam int SUM_BITS       = 34;
    localparam int S_TDATA_BITS   = 24;
    localparam int M_TDATA_BITS   = 40;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_XOR    = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_Q_RD,
        ST_Q_STEP,
        ST_FIN_MUL,
        ST_FIN_ACC,
        ST_FIN_OUT
    } state_t;

    typedef enum logic [1:0] {
        ADDR_CLEAR,
        ADDR_CHECK,
        ADDR_WALK,
        ADDR_PREF
    } addr_sel_t;

    typedef struct packed {
        logic      accept;
        logic      mask_upd;
        addr_sel_t addr_sel;
        logic      ram_we;
        logic      clr_step;
        logic      walk_init;
        logic      walk_step;
        logic      q_init;
        logic      q_step;
        logic      fin_init;
        logic      fin_step;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic chk_ok;
        logic lvl_zero;
        logic out_free;
        op_t  op;
        op_t  in_op;
    } sts_t;

endpackage
`default_nettype wire

// ===== design/xor_trie_k_smallest_sum_unit.sv =====
// Insert and remove do a check read, then a read and a write of each of
// VALUE_BITS+1 trie nodes through the single node memory port; a dropped one
// goes back to idle after the check. Query does one node read per level, then
// a bit-serial fold of the per-bit counts. An XOR update needs no trie access.
// One item at a time. Reset is synchronous, active low; after reset a clearing
// pass over all 2^(VALUE_BITS+1) addresses zeroes the node memory before any item is taken.
`timescale 1ns / 1ps
`default_nettype none
module xor_trie_k_smallest_sum_unit #(
    parameter int VALUE_BITS = xtks_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = xtks_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // operation [1:0], operand [19:2], zero fill above
    input  wire logic [xtks_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // smallest_sum [33:0], zero fill above
    output logic      [xtks_pkg::M_TDATA_BITS-1:0] m_tdata
);

    xtks_pkg::cmd_t cmd;
    xtks_pkg::sts_t sts;

    xtks_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    xtks_datapath #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

`ifndef SYNTH
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready straight after reset");

    a_write_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ram_we |-> !s_tready)
        else $error("node memory written while taking items");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

    a_accept_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept || cmd.mask_upd) |-> (s_tvalid && s_tready && !cmd.out_load))
        else $error("item latched outside a handshake");
`endif

endmodule
`default_nettype wire

// ===== design/xtks_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xtks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== design/xtks_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xtks_datapath #(
    parameter int VALUE_BITS = xtks_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = xtks_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire xtks_pkg::cmd_t                    cmd,
    output xtks_pkg::sts_t                         sts,
    input  wire logic [xtks_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [xtks_pkg::M_TDATA_BITS-1:0] m_tdata
);

    localparam int AW = VALUE_BITS + 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int RW = AW * CW;
    localparam int LW = $clog2(VALUE_BITS + 1);
    localparam int IW = $clog2(VALUE_BITS);
    localparam int SW = CW + VALUE_BITS + 1;
    localparam int OW = (SW > xtks_pkg::SUM_BITS) ? SW : xtks_pkg::SUM_BITS;
    localparam int XW = (VALUE_BITS > xtks_pkg::OPERAND_BITS) ?
                        VALUE_BITS : xtks_pkg::OPERAND_BITS;
    localparam int KW = (CW > xtks_pkg::OPERAND_BITS) ? CW : xtks_pkg::OPERAND_BITS;

    logic [VALUE_BITS-1:0]             mask_reg;
    logic [VALUE_BITS-1:0]             v_reg;
    xtks_pkg::op_t                     op_reg;
    logic [xtks_pkg::OPERAND_BITS-1:0] k_reg;
    logic [AW-1:0]                     node_reg;
    logic [LW-1:0]                     lvl_reg;
    logic [CW-1:0]                     rem_reg;
    logic [CW-1:0]                     acc_reg [VALUE_BITS];
    logic [SW-1:0]                     sum_reg;
    logic [SW-1:0]                     prod_reg;
    logic [AW-1:0]                     clr_addr_reg;
    logic [xtks_pkg::SUM_BITS-1:0]     out_data_reg;
    logic                              out_valid_reg;

    logic [xtks_pkg::OPERAND_BITS-1:0] operand;
    logic [XW-1:0]                     opnd_x;
    logic [VALUE_BITS-1:0]             opnd_v;
    logic [LW-1:0]                     lvl_dec;
    logic [IW-1:0]                     lvl_idx;
    logic [IW-1:0]                     walk_idx;
    logic [AW-1:0]                     pref;
    logic [AW-1:0]                     ram_addr;
    logic [RW-1:0]                     ram_wdata;
    logic [RW-1:0]                     ram_rdata;
    logic [RW-1:0]                     row_mod;
    logic [CW-1:0]                     total_rd;
    logic [CW-1:0]                     delta;
    logic                              ge;
    logic [CW-1:0]                     cnt [VALUE_BITS];
    logic [VALUE_BITS-1:0]             leaf_val;
    logic [CW+VALUE_BITS-1:0]          prod;
    logic [SW-1:0]                     horner;
    logic [SW-1:0]                     total_sum;
    logic [OW-1:0]                     total_wide;

    assign operand  = s_tdata[xtks_pkg::OP_BITS +: xtks_pkg::OPERAND_BITS];
    assign opnd_x   = XW'(operand);
    assign opnd_v   = opnd_x[VALUE_BITS-1:0];
    assign lvl_dec  = lvl_reg - LW'(1);
    assign lvl_idx  = lvl_reg[IW-1:0];
    assign walk_idx = lvl_dec[IW-1:0];
    assign pref     = {node_reg[AW-2:0], mask_reg[lvl_idx]};
    assign total_rd = ram_rdata[CW-1:0];
    assign ge       = total_rd >= rem_reg;
    assign delta    = (op_reg == xtks_pkg::OP_INSERT) ? CW'(1) : {CW{1'b1}};

    always_comb begin
        case (cmd.addr_sel)
            xtks_pkg::ADDR_CLEAR: ram_addr = clr_addr_reg;
            xtks_pkg::ADDR_CHECK: ram_addr = (op_reg == xtks_pkg::OP_REMOVE) ?
                                             {1'b1, v_reg} : AW'(1);
            xtks_pkg::ADDR_WALK:  ram_addr = node_reg;
            xtks_pkg::ADDR_PREF:  ram_addr = pref;
            default:              ram_addr = node_reg;
        endcase
    end

    // Add delta (+1 insert, -1 remove) to the node total and the tally of every set bit of the value
    always_comb begin
        row_mod[CW-1:0] = total_rd + delta;
        for (int j = 0; j < VALUE_BITS; j++) begin
            row_mod[(j+1)*CW +: CW] = ram_rdata[(j+1)*CW +: CW] +
                                      (v_reg[j] ? delta : CW'(0));
        end
    end

    always_comb begin
        for (int j = 0; j < VALUE_BITS; j++) begin
            cnt[j] = mask_reg[j] ? (total_rd - ram_rdata[(j+1)*CW +: CW]) :
                                   ram_rdata[(j+1)*CW +: CW];
        end
    end

    assign ram_wdata  = cmd.clr_step ? '0 : row_mod;
    assign leaf_val   = node_reg[VALUE_BITS-1:0] ^ mask_reg;
    assign prod       = rem_reg * leaf_val;
    assign horner     = {sum_reg[SW-2:0], 1'b0} + SW'(acc_reg[lvl_idx]);
    assign total_sum  = sum_reg + prod_reg;
    assign total_wide = OW'(total_sum);

    xtks_ram #(
        .WIDTH(RW),
        .DEPTH(2 ** AW)
    ) u_node_ram (
        .aclk (aclk),
        .we   (cmd.ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.mask_upd) begin
                mask_reg <= mask_reg ^ opnd_v;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= xtks_pkg::op_t'(s_tdata[xtks_pkg::OP_BITS-1:0]);
            v_reg  <= opnd_v ^ mask_reg;
            k_reg  <= operand;
        end
        if (cmd.walk_init) begin
            node_reg <= AW'(1);
            lvl_reg  <= LW'(VALUE_BITS);
        end
        if (cmd.walk_step) begin
            if (lvl_reg != '0) begin
                node_reg <= {node_reg[AW-2:0], v_reg[walk_idx]};
            end
            lvl_reg <= lvl_dec;
        end
        if (cmd.q_init) begin
            rem_reg  <= (KW'(k_reg) > KW'(total_rd)) ? total_rd : CW'(k_reg);
            node_reg <= AW'(1);
            lvl_reg  <= LW'(VALUE_BITS - 1);
            for (int j = 0; j < VALUE_BITS; j++) begin
                acc_reg[j] <= '0;
            end
        end
        // Descend into the preferred child, or take it whole and go to its sibling
        if (cmd.q_step) begin
            if (ge) begin
                node_reg <= pref;
            end else begin
                node_reg <= {pref[AW-1:1], ~pref[0]};
                rem_reg  <= rem_reg - total_rd;
                for (int j = 0; j < VALUE_BITS; j++) begin
                    acc_reg[j] <= acc_reg[j] + cnt[j];
                end
            end
            lvl_reg <= lvl_dec;
        end
        if (cmd.fin_init) begin
            prod_reg <= SW'(prod);
            sum_reg  <= '0;
            lvl_reg  <= LW'(VALUE_BITS - 1);
        end
        if (cmd.fin_step) begin
            sum_reg <= horner;
            lvl_reg <= lvl_dec;
        end
        if (cmd.out_load) begin
            out_data_reg <= total_wide[xtks_pkg::SUM_BITS-1:0];
        end
    end

    always_comb begin
        sts.clr_done = &clr_addr_reg;
        sts.lvl_zero = (lvl_reg == '0);
        sts.out_free = !out_valid_reg || m_tready;
        sts.op       = op_reg;
        sts.in_op    = xtks_pkg::op_t'(s_tdata[xtks_pkg::OP_BITS-1:0]);
        case (op_reg)
            xtks_pkg::OP_INSERT: sts.chk_ok = total_rd < CW'(MAX_ITEMS);
            xtks_pkg::OP_REMOVE: sts.chk_ok = total_rd != '0;
            default:             sts.chk_ok = 1'b1;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = xtks_pkg::M_TDATA_BITS'(out_data_reg);

endmodule
`default_nettype wire

// ===== design/xtks_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xtks_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire xtks_pkg::sts_t sts,
    output xtks_pkg::cmd_t      cmd
);

    xtks_pkg::state_t state_reg;
    xtks_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xtks_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = xtks_pkg::ADDR_WALK;
        s_tready     = 1'b0;
        case (state_reg)
            xtks_pkg::ST_CLEAR: begin
                cmd.addr_sel = xtks_pkg::ADDR_CLEAR;
                cmd.ram_we   = 1'b1;
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = xtks_pkg::ST_IDLE;
                end
            end
            xtks_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (sts.in_op == xtks_pkg::OP_XOR) begin
                        cmd.mask_upd = 1'b1;
                    end else begin
                        cmd.accept = 1'b1;
                        state_next = xtks_pkg::ST_CHK_RD;
                    end
                end
            end
            xtks_pkg::ST_CHK_RD: begin
                cmd.addr_sel = xtks_pkg::ADDR_CHECK;
                state_next   = xtks_pkg::ST_CHK;
            end
            xtks_pkg::ST_CHK: begin
                cmd.addr_sel = xtks_pkg::ADDR_CHECK;
                if (sts.op == xtks_pkg::OP_QUERY) begin
                    cmd.q_init = 1'b1;
                    state_next = xtks_pkg::ST_Q_RD;
                end else if (sts.chk_ok) begin
                    cmd.walk_init = 1'b1;
                    state_next    = xtks_pkg::ST_UPD_RD;
                end else begin
                    // drop: store full or value absent
                    state_next = xtks_pkg::ST_IDLE;
                end
            end
            xtks_pkg::ST_UPD_RD: begin
                state_next = xtks_pkg::ST_UPD_WR;
            end
            xtks_pkg::ST_UPD_WR: begin
                cmd.ram_we    = 1'b1;
                cmd.walk_step = 1'b1;
                state_next    = sts.lvl_zero ? xtks_pkg::ST_IDLE : xtks_pkg::ST_UPD_RD;
            end
            xtks_pkg::ST_Q_RD: begin
                cmd.addr_sel = xtks_pkg::ADDR_PREF;
                state_next   = xtks_pkg::ST_Q_STEP;
            end
            xtks_pkg::ST_Q_STEP: begin
                cmd.addr_sel = xtks_pkg::ADDR_PREF;
                cmd.q_step   = 1'b1;
                state_next   = sts.lvl_zero ? xtks_pkg::ST_FIN_MUL : xtks_pkg::ST_Q_RD;
            end
            xtks_pkg::ST_FIN_MUL: begin
                cmd.fin_init = 1'b1;
                state_next   = xtks_pkg::ST_FIN_ACC;
            end
            xtks_pkg::ST_FIN_ACC: begin
                cmd.fin_step = 1'b1;
                if (sts.lvl_zero) begin
                    state_next = xtks_pkg::ST_FIN_OUT;
                end
            end
            xtks_pkg::ST_FIN_OUT: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = xtks_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xtks_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import xtks_pkg::*;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // operation [1:0], operand [19:2], zero fill above
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    // smallest_sum [33:0], zero fill above
    logic [M_TDATA_BITS-1:0] m_tdata;

    xor_trie_k_smallest_sum_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    localparam int IDLE_PCT = 21;

    // shadow multiset of stored values with multiplicity
    int unsigned               held_count[bit [VALUE_BITS_DEF-1:0]];
    int unsigned               held_total;
    logic [VALUE_BITS_DEF-1:0] shadow_mask;
    logic [SUM_BITS-1:0]       sums_due[$];
    bit                        no_idle;
    int                        errors;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [SUM_BITS-1:0] k_smallest_sum(int unsigned k);
        logic [VALUE_BITS_DEF-1:0] vals[$];
        logic [SUM_BITS-1:0]       acc;
        acc = '0;
        foreach (held_count[v])
            for (int unsigned n = 0; n < held_count[v]; n++)
                vals.insert(vals.size(), v ^ shadow_mask);
        vals.sort();
        if (k > vals.size()) k = vals.size();
        for (int unsigned i = 0; i < k; i++) acc += SUM_BITS'(vals[i]);
        return acc;
    endfunction

    task automatic apply_item(op_t op, logic [OPERAND_BITS-1:0] arg);
        logic [VALUE_BITS_DEF-1:0] v;
        v = arg ^ shadow_mask;
        case (op)
            OP_INSERT: begin
                if (held_total < MAX_ITEMS_DEF) begin
                    held_count[v] = held_count.exists(v) ? held_count[v] + 1 : 1;
                    held_total++;
                end
            end
            OP_REMOVE: begin
                if (held_count.exists(v)) begin
                    if (held_count[v] == 1) held_count.delete(v);
                    else held_count[v] = held_count[v] - 1;
                    held_total--;
                end
            end
            OP_XOR:   shadow_mask = shadow_mask ^ arg;
            default:  sums_due.insert(sums_due.size(), k_smallest_sum(arg));
        endcase
    endtask

    task automatic send_item(op_t op, logic [OPERAND_BITS-1:0] arg);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, arg, op};
        do @(posedge aclk); while (!s_tready);
        apply_item(op, arg);
    endtask

    task automatic test_directed();
        send_item(OP_QUERY, 18'd0);
        send_item(OP_QUERY, 18'h3FFFF);
        send_item(OP_REMOVE, 18'd5);
        send_item(OP_INSERT, 18'd0);
        send_item(OP_INSERT, 18'h3FFFF);
        send_item(OP_INSERT, 18'h3FFFF);
        send_item(OP_INSERT, 18'h15555);
        send_item(OP_QUERY, 18'd1);
        send_item(OP_QUERY, 18'd3);
        send_item(OP_QUERY, 18'h3FFFF);
        send_item(OP_XOR, 18'h3FFFF);
        send_item(OP_QUERY, 18'd2);
        send_item(OP_QUERY, 18'd4);
        send_item(OP_REMOVE, 18'h3FFFF);  // removes stored zero
        send_item(OP_REMOVE, 18'h3FFFF);  // now absent, ignored
        send_item(OP_QUERY, 18'h3FFFF);
        send_item(OP_XOR, 18'h2AAAA);
        send_item(OP_INSERT, 18'h12345);
        send_item(OP_QUERY, 18'd0);
        send_item(OP_QUERY, 18'd2);
        send_item(OP_XOR, 18'd0);
        send_item(OP_QUERY, 18'h3FFFF);
    endtask

    task automatic random_items(int count);
        int                        r;
        logic [OPERAND_BITS-1:0]   arg;
        logic [VALUE_BITS_DEF-1:0] keys[$];
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                // cluster values so duplicates and shared prefixes occur
                arg = ($urandom_range(1)) ? 18'($urandom) : 18'($urandom_range(31));
                send_item(OP_INSERT, arg);
            end else if (r < 55) begin
                keys.delete();
                foreach (held_count[v]) keys.insert(keys.size(), v);
                if (keys.size() > 0 && $urandom_range(9) < 7)
                    arg = keys[$urandom_range(keys.size() - 1)] ^ shadow_mask;
                else
                    arg = 18'($urandom);
                send_item(OP_REMOVE, arg);
            end else if (r < 65) begin
                send_item(OP_XOR, 18'($urandom));
            end else begin
                case ($urandom_range(3))
                    0:       arg = 18'($urandom);
                    1:       arg = '0;
                    default: arg = 18'($urandom_range(held_total + 2));
                endcase
                send_item(OP_QUERY, arg);
            end
        end
    endtask

    task automatic test_random();
        random_items(1000);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        random_items(380);
        no_idle = 1'b0;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sums_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: sum %0d", m_tdata[SUM_BITS-1:0]);
            end else begin
                if (m_tdata[SUM_BITS-1:0] !== sums_due[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("sum mismatch: expected %0d actual %0d",
                                 sums_due[0], m_tdata[SUM_BITS-1:0]);
                end
                void'(sums_due.pop_front());
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        no_idle     = 1'b0;
        errors      = 0;
        held_total  = 0;
        shadow_mask = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (sums_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/xtks_pkg.sv
design/xtks_ram.sv
design/xtks_datapath.sv
design/xtks_ctrl.sv
design/xor_trie_k_smallest_sum_unit.sv
bench/tb.sv
